### hdl/ghdm_pkg.sv
`default_nettype none

package ghdm_pkg;

  localparam int MAX_TRAIN = 512;
  localparam int NUM_LANES = 8;
  localparam int LANE_W    = $clog2(NUM_LANES);
  localparam int ROWS      = MAX_TRAIN / NUM_LANES;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int NROW_W    = $clog2(ROWS + 1);
  localparam int IDX_W     = ROW_W + LANE_W;
  localparam int CNT_W     = $clog2(MAX_TRAIN + 1);
  localparam int WORD_W    = 64;
  localparam int NUM_WORDS = 4;
  localparam int DESC_W    = WORD_W * NUM_WORDS;
  localparam int TAG_W     = 16;
  localparam int DIST_W    = 9;
  localparam int POP_W     = 7;
  localparam int MAXD_W    = 9;
  localparam int OP_W      = 2;
  localparam int QDEPTH    = 2;

  localparam logic [MAXD_W-1:0] MAXD_RESET = MAXD_W'(64);
  localparam logic [DIST_W-1:0] DIST_NONE  = DIST_W'(256);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [DESC_W-1:0] desc;
    logic [TAG_W-1:0]  tag;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } back_state_t;

  typedef struct packed {
    logic              v;
    logic [DIST_W-1:0] hd;
    logic [IDX_W-1:0]  idx;
  } cand_t;

  function automatic logic [3:0] pop8(logic [7:0] x);
    logic [3:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 4'(x[i]);
    end
    return s;
  endfunction

  function automatic logic [POP_W-1:0] pop64(logic [WORD_W-1:0] x);
    logic [POP_W-1:0] s;
    s = '0;
    for (int i = 0; i < WORD_W / 8; i++) begin
      s = s + POP_W'(pop8(x[i*8 +: 8]));
    end
    return s;
  endfunction

  // lower index sits in a, so a keeps ties
  function automatic cand_t cand_pick(cand_t a, cand_t b);
    if (a.v && (!b.v || a.hd <= b.hd)) begin
      return a;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

### hdl/ghdm_in_if.sv
`default_nettype none

interface ghdm_in_if;
  import ghdm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [WORD_W-1:0]    desc_word0;
  logic [WORD_W-1:0]    desc_word1;
  logic [WORD_W-1:0]    desc_word2;
  logic [WORD_W-1:0]    desc_word3;
  logic [TAG_W-1:0]     query_tag;

  modport source (
    output valid, operation, desc_word0, desc_word1, desc_word2, desc_word3, query_tag,
    input  ready
  );

  modport sink (
    input  valid, operation, desc_word0, desc_word1, desc_word2, desc_word3, query_tag,
    output ready
  );
endinterface

`default_nettype wire

### hdl/ghdm_out_if.sv
`default_nettype none

interface ghdm_out_if;
  import ghdm_pkg::*;

  logic               valid;
  logic               ready;
  logic               matched;
  logic [TAG_W-1:0]   query_tag_out;
  logic [IDX_W-1:0]   train_index;
  logic [DIST_W-1:0]  best_distance;

  modport source (
    output valid, matched, query_tag_out, train_index, best_distance,
    input  ready
  );

  modport sink (
    input  valid, matched, query_tag_out, train_index, best_distance,
    output ready
  );
endinterface

`default_nettype wire

### hdl/ghdm_front.sv
`default_nettype none

module ghdm_front (
  ghdm_in_if.sink        in_chan,
  input  logic           q_full,
  output logic           q_push,
  output ghdm_pkg::cmd_t q_wcmd
);
  import ghdm_pkg::*;

  logic accept;
  logic known_op;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    unique case (in_chan.operation)
      OP_CLEAR, OP_APPEND, OP_QUERY: known_op = 1'b1;
      default:                       known_op = 1'b0;
    endcase
  end

  // drop words with an unknown operation
  assign q_push      = accept && known_op;
  assign q_wcmd.op   = op_t'(in_chan.operation);
  assign q_wcmd.desc = {in_chan.desc_word3, in_chan.desc_word2,
                        in_chan.desc_word1, in_chan.desc_word0};
  assign q_wcmd.tag  = in_chan.query_tag;

endmodule

`default_nettype wire

### hdl/ghdm_cmd_queue.sv
`default_nettype none

module ghdm_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ghdm_pkg::cmd_t wcmd,
  output logic           full,
  input  logic           pop,
  output logic           rvalid,
  output ghdm_pkg::cmd_t rcmd
);
  import ghdm_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  cmd_t              mem_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign rvalid  = (cnt_r != '0);
  assign rcmd    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && rvalid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wcmd;
    end
  end

endmodule

`default_nettype wire

### hdl/ghdm_bank.sv
`default_nettype none

module ghdm_bank (
  input  logic                       clk,
  input  logic                       desc_we,
  input  logic [ghdm_pkg::ROW_W-1:0] desc_row,
  input  logic [ghdm_pkg::DESC_W-1:0] desc_wdata,
  input  logic                       mark_we,
  input  logic [ghdm_pkg::ROW_W-1:0] mark_row,
  input  logic                       mark_wdata,
  input  logic                       rd_en,
  input  logic [ghdm_pkg::ROW_W-1:0] rd_row,
  output logic [ghdm_pkg::DESC_W-1:0] rd_desc_r,
  output logic                       rd_mark_r
);
  import ghdm_pkg::*;

  logic [DESC_W-1:0] desc_mem [ROWS];
  logic              mark_mem [ROWS];

  always_ff @(posedge clk) begin
    if (desc_we) begin
      desc_mem[desc_row] <= desc_wdata;
    end
    if (mark_we) begin
      mark_mem[mark_row] <= mark_wdata;
    end
    if (rd_en) begin
      rd_desc_r <= desc_mem[rd_row];
      rd_mark_r <= mark_mem[rd_row];
    end
  end

endmodule

`default_nettype wire

### hdl/ghdm_back.sv
`default_nettype none

module ghdm_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [ghdm_pkg::MAXD_W-1:0] cfg_wdata,
  input  logic                        q_valid,
  input  ghdm_pkg::cmd_t              q_cmd,
  output logic                        q_pop,
  ghdm_out_if.source                  out_chan
);
  import ghdm_pkg::*;

  back_state_t       state_r;
  back_state_t       state_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [MAXD_W-1:0] maxd_r;
  logic [ROW_W-1:0]  row_r;
  logic [NROW_W-1:0] nrows;
  logic [CNT_W:0]    count_up;
  logic              last_row;
  logic              room;

  logic              issue;
  logic              do_clear;
  logic              do_append;
  logic              start_query;
  logic              load_result;
  logic              can_load;

  logic [DESC_W-1:0] bank_desc [NUM_LANES];
  logic              bank_mark [NUM_LANES];
  logic              mark_we;
  logic [ROW_W-1:0]  mark_row;
  logic [LANE_W-1:0] mark_lane;
  logic              mark_val;
  logic [ROW_W-1:0]  app_row;
  logic [LANE_W-1:0] app_lane;

  logic              p1_v_r;
  logic [ROW_W-1:0]  p1_row_r;
  logic              p2_v_r;
  logic [ROW_W-1:0]  p2_row_r;
  logic [NUM_LANES-1:0] p2_mask_r;
  logic [POP_W-1:0]  p2_pop_r [NUM_LANES][NUM_WORDS];
  logic              p3_v_r;
  logic [ROW_W-1:0]  p3_row_r;
  logic [NUM_LANES-1:0] p3_mask_r;
  logic [DIST_W-1:0] p3_dist_r [NUM_LANES];
  logic [NUM_LANES-1:0] p1_mask;

  cand_t             lvl0 [NUM_LANES];
  cand_t             lvl1 [NUM_LANES/2];
  cand_t             lvl2 [NUM_LANES/4];
  cand_t             win;

  logic              best_found_r;
  logic [DIST_W-1:0] best_dist_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic              hit;

  logic              out_valid_r;
  logic              out_matched_r;
  logic [TAG_W-1:0]  out_tag_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [DIST_W-1:0] out_dist_r;

  assign count_up = {1'b0, count_r} + (CNT_W+1)'(NUM_LANES - 1);
  assign nrows    = NROW_W'(count_up >> LANE_W);
  assign last_row = ({1'b0, row_r} == nrows - 1'b1);
  assign room     = (count_r < CNT_W'(MAX_TRAIN));
  assign app_row  = count_r[IDX_W-1:LANE_W];
  assign app_lane = count_r[LANE_W-1:0];
  assign can_load = !out_valid_r || out_chan.ready;
  assign hit      = best_found_r && ({1'b0, best_dist_r} < {1'b0, maxd_r});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && q_cmd.op == OP_QUERY) begin
          state_nxt = (nrows == '0) ? ST_DRAIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_row) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!p1_v_r && !p2_v_r && !p3_v_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (can_load) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    issue       = 1'b0;
    do_clear    = 1'b0;
    do_append   = 1'b0;
    start_query = 1'b0;
    load_result = 1'b0;
    q_pop       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.op)
            OP_CLEAR: begin
              do_clear = 1'b1;
              q_pop    = 1'b1;
            end
            OP_APPEND: begin
              do_append = room;
              q_pop     = 1'b1;
            end
            OP_QUERY: begin
              start_query = 1'b1;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        issue = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_DONE: begin
        load_result = can_load;
        q_pop       = can_load;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      maxd_r  <= MAXD_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        maxd_r <= cfg_wdata;
      end
      if (do_clear) begin
        count_r <= '0;
      end else if (do_append) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_query) begin
      row_r <= '0;
    end else if (issue) begin
      row_r <= row_r + 1'b1;
    end
  end

  // mark new entries free on append, mark the winner taken on a match
  always_comb begin
    mark_we   = 1'b0;
    mark_row  = app_row;
    mark_lane = app_lane;
    mark_val  = 1'b0;
    if (do_append) begin
      mark_we = 1'b1;
    end else if (load_result && hit) begin
      mark_we   = 1'b1;
      mark_row  = best_idx_r[IDX_W-1:LANE_W];
      mark_lane = best_idx_r[LANE_W-1:0];
      mark_val  = 1'b1;
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    ghdm_bank u_bank (
      .clk        (clk),
      .desc_we    (do_append && app_lane == LANE_W'(l)),
      .desc_row   (app_row),
      .desc_wdata (q_cmd.desc),
      .mark_we    (mark_we && mark_lane == LANE_W'(l)),
      .mark_row   (mark_row),
      .mark_wdata (mark_val),
      .rd_en      (issue),
      .rd_row     (row_r),
      .rd_desc_r  (bank_desc[l]),
      .rd_mark_r  (bank_mark[l])
    );

    assign p1_mask[l] = (CNT_W'({p1_row_r, LANE_W'(l)}) < count_r) && !bank_mark[l];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else begin
      p1_v_r <= issue;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_row_r  <= row_r;
    p2_row_r  <= p1_row_r;
    p2_mask_r <= p1_mask;
    p3_row_r  <= p2_row_r;
    p3_mask_r <= p2_mask_r;
    for (int l = 0; l < NUM_LANES; l++) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        p2_pop_r[l][w] <= pop64(bank_desc[l][w*WORD_W +: WORD_W] ^
                                q_cmd.desc[w*WORD_W +: WORD_W]);
      end
      p3_dist_r[l] <= DIST_W'(p2_pop_r[l][0]) + DIST_W'(p2_pop_r[l][1]) +
                      DIST_W'(p2_pop_r[l][2]) + DIST_W'(p2_pop_r[l][3]);
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      lvl0[l].v   = p3_mask_r[l];
      lvl0[l].hd  = p3_dist_r[l];
      lvl0[l].idx = {p3_row_r, LANE_W'(l)};
    end
    for (int k = 0; k < NUM_LANES / 2; k++) begin
      lvl1[k] = cand_pick(lvl0[2*k], lvl0[2*k+1]);
    end
    for (int k = 0; k < NUM_LANES / 4; k++) begin
      lvl2[k] = cand_pick(lvl1[2*k], lvl1[2*k+1]);
    end
    win = cand_pick(lvl2[0], lvl2[1]);
  end

  always_ff @(posedge clk) begin
    if (start_query) begin
      best_found_r <= 1'b0;
      best_dist_r  <= DIST_NONE;
      best_idx_r   <= '0;
    end else if (p3_v_r && win.v && (!best_found_r || win.hd < best_dist_r)) begin
      best_found_r <= 1'b1;
      best_dist_r  <= win.hd;
      best_idx_r   <= win.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_result) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      out_matched_r <= hit;
      out_tag_r     <= q_cmd.tag;
      out_idx_r     <= hit ? best_idx_r : '0;
      out_dist_r    <= best_dist_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.matched       = out_matched_r;
  assign out_chan.query_tag_out = out_tag_r;
  assign out_chan.train_index   = out_idx_r;
  assign out_chan.best_distance = out_dist_r;

endmodule

`default_nettype wire

### hdl/greedy_hamming_descriptor_matcher.sv
// Greedy Hamming matcher for 256-bit descriptors, up to 512 train entries.
// in_chan (valid/ready): one word per operation: clear, append a train
//   descriptor, or query. Unknown operation codes are taken and dropped.
//   Words pass a two-deep command queue, so input can still be taken while
//   the engine is busy or the result is stalled, until the queue is full.
// out_chan (valid/ready): one result word per query; clear and append give
//   none. The result sits in an output register until taken.
// cfg_we/cfg_wdata: write max_distance (reset value 64) while idle.
// Engine: a query reads 8 entries per cycle from eight banked stores; the
//   finished result is loaded into the output register once that register
//   is free.
// Reset clears the count, the queue and the output register; no clearing
//   pass is needed, since used-marks are rewritten on each append.
// When out_chan stalls, the engine holds a finished query until the output
//   register frees up, and the queue then fills and drops in_chan.ready.
`default_nettype none

module greedy_hamming_descriptor_matcher (
  input  logic                        clk,
  input  logic                        rst_n,
  ghdm_in_if.sink                     in_chan,
  ghdm_out_if.source                  out_chan,
  input  logic                        cfg_we,
  input  logic [ghdm_pkg::MAXD_W-1:0] cfg_wdata
);
  import ghdm_pkg::*;

  logic q_full;
  logic q_push;
  cmd_t q_wcmd;
  logic q_pop;
  logic q_valid;
  cmd_t q_rcmd;

  ghdm_front u_front (
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wcmd  (q_wcmd)
  );

  ghdm_cmd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wcmd   (q_wcmd),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rcmd   (q_rcmd)
  );

  ghdm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_cmd     (q_rcmd),
    .q_pop     (q_pop),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

### hdl/ghdm_checker.sv
`default_nettype none

module ghdm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_matched,
  input logic [15:0] out_tag,
  input logic [8:0] out_train_index,
  input logic [8:0] out_best_distance
);

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_matched) && $stable(out_tag) &&
      $stable(out_train_index) && $stable(out_best_distance))
    else $error("result word changed while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_matched |-> out_train_index == 9'd0)
    else $error("train index nonzero without a match");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_best_distance <= 9'd256)
    else $error("distance beyond descriptor width");

  assert property (@(posedge clk)
    rst_n && $past(rst_n) == 1'b0 |-> !out_valid)
    else $error("result word present right after reset");

endmodule

bind greedy_hamming_descriptor_matcher ghdm_checker u_ghdm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_matched       (out_chan.matched),
  .out_tag           (out_chan.query_tag_out),
  .out_train_index   (out_chan.train_index),
  .out_best_distance (out_chan.best_distance)
);

`default_nettype wire

### test/testbench.sv
`default_nettype none

module testbench;
  import ghdm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 80;
  localparam int DRAIN_LIMIT = 20000;

  typedef logic [DESC_W-1:0] desc_t;

  typedef struct {
    logic              matched;
    logic [TAG_W-1:0]  tag;
    logic [IDX_W-1:0]  index;
    logic [DIST_W-1:0] hd;
  } match_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [MAXD_W-1:0]   cfg_wdata;

  ghdm_in_if  in_chan ();
  ghdm_out_if out_chan ();

  greedy_hamming_descriptor_matcher dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  desc_t  train_desc [MAX_TRAIN];
  bit     train_used [MAX_TRAIN];
  int     train_count;
  int     max_dist;
  match_t pending_matches[$];

  bit no_gaps;
  int errors;
  int words_sent;
  int queries_sent;
  int results_seen;
  int matches_seen;
  int thresholds_set;

  initial begin
    clk = 1'b0;
    forever begin
      #1 clk = ~clk;
    end
  end

  initial begin
    #1ms;
    $display("timeout: %0d results still expected", pending_matches.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready <= no_gaps || ($urandom_range(99) >= 9);
    end
  end

  task automatic report_error(string msg);
    $display("ERROR %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic desc_t random_desc();
    return {$urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic match_t search_store(desc_t query, logic [TAG_W-1:0] tag);
    match_t r;
    int     best;
    int     best_i;
    int     d;
    bit     found;
    best   = 256;
    best_i = 0;
    found  = 1'b0;
    for (int i = 0; i < train_count; i++) begin
      if (!train_used[i]) begin
        d = $countones(query ^ train_desc[i]);
        if (!found || d < best) begin
          found  = 1'b1;
          best   = d;
          best_i = i;
        end
      end
    end
    r.tag = tag;
    r.hd  = DIST_W'(best);
    if (found && best < max_dist) begin
      train_used[best_i] = 1'b1;
      r.matched = 1'b1;
      r.index   = IDX_W'(best_i);
    end else begin
      r.matched = 1'b0;
      r.index   = '0;
    end
    return r;
  endfunction

  task automatic predict_word(logic [OP_W-1:0] op, desc_t desc, logic [TAG_W-1:0] tag);
    case (op)
      OP_CLEAR: begin
        train_count = 0;
        foreach (train_used[i]) train_used[i] = 1'b0;
      end
      OP_APPEND: begin
        if (train_count < MAX_TRAIN) begin
          train_desc[train_count] = desc;
          train_used[train_count] = 1'b0;
          train_count++;
        end
      end
      OP_QUERY: begin
        pending_matches.insert(pending_matches.size(), search_store(desc, tag));
        queries_sent++;
      end
      default: ;
    endcase
  endtask

  task automatic send_word(logic [OP_W-1:0] op, desc_t desc, logic [TAG_W-1:0] tag);
    @(negedge clk);
    while (!no_gaps && $urandom_range(99) < 9) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.operation  <= op;
    in_chan.desc_word0 <= desc[63:0];
    in_chan.desc_word1 <= desc[127:64];
    in_chan.desc_word2 <= desc[191:128];
    in_chan.desc_word3 <= desc[255:192];
    in_chan.query_tag  <= tag;
    in_chan.valid      <= 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    predict_word(op, desc, tag);
    words_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_chan.valid <= 1'b0;
  endtask

  task automatic wait_results();
    release_input();
    while (pending_matches.size() != 0) @(posedge clk);
  endtask

  task automatic set_threshold(int value);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= MAXD_W'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
    max_dist = value;
    thresholds_set++;
  endtask

  task automatic check_result();
    match_t want;
    if (pending_matches.size() == 0) begin
      report_error($sformatf("result with no query waiting, tag %h",
                             out_chan.query_tag_out));
    end else begin
      want = pending_matches.pop_front();
      if (out_chan.matched !== want.matched)
        report_error($sformatf("tag %h matched %b, want %b", want.tag,
                               out_chan.matched, want.matched));
      if (out_chan.query_tag_out !== want.tag)
        report_error($sformatf("tag %h, want %h", out_chan.query_tag_out, want.tag));
      if (out_chan.train_index !== want.index)
        report_error($sformatf("tag %h index %0d, want %0d", want.tag,
                               out_chan.train_index, want.index));
      if (out_chan.best_distance !== want.hd)
        report_error($sformatf("tag %h distance %0d, want %0d", want.tag,
                               out_chan.best_distance, want.hd));
    end
    results_seen++;
    if (out_chan.matched === 1'b1) matches_seen++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) check_result();
  end

  task automatic send_near_query();
    desc_t q;
    int    flips;
    if (train_count == 0) begin
      send_word(OP_QUERY, random_desc(), 16'($urandom));
    end else begin
      q     = train_desc[$urandom_range(train_count - 1)];
      flips = $urandom_range(0, (max_dist > 200) ? 200 : max_dist + 4);
      repeat (flips) q[$urandom_range(DESC_W - 1)] ^= 1'b1;
      send_word(OP_QUERY, q, 16'($urandom));
    end
  endtask

  task automatic test_directed();
    desc_t r;
    r = random_desc();
    send_word(OP_QUERY, '1, 16'hFFFF);
    send_word(OP_UNUSED, random_desc(), 16'($urandom));
    send_word(OP_APPEND, '0, 16'($urandom));
    send_word(OP_APPEND, '1, 16'($urandom));
    send_word(OP_APPEND, {192'b0, 64'hFFFF_FFFF_FFFF_FFFF}, 16'h0);
    send_word(OP_QUERY, '0, 16'h0000);
    send_word(OP_QUERY, '0, 16'h0001);
    send_word(OP_APPEND, {192'b0, 64'hFFFF_FFFF_FFFF_FFFE}, 16'h0);
    send_word(OP_QUERY, '0, 16'h0002);
    send_word(OP_APPEND, '1, 16'h0);
    send_word(OP_QUERY, '1, 16'h0003);
    send_word(OP_QUERY, '1, 16'h0004);
    send_word(OP_QUERY, '1, 16'h0005);
    send_word(OP_CLEAR, random_desc(), 16'($urandom));
    send_word(OP_APPEND, r, 16'h0);
    send_word(OP_QUERY, r, 16'h0006);
    send_word(OP_QUERY, r, 16'h0007);
    send_word(OP_CLEAR, '1, 16'hFFFF);
    send_word(OP_QUERY, random_desc(), 16'h0008);
    send_word(OP_APPEND, '1, 16'h0);
    send_word(OP_QUERY, '0, 16'h0009);
  endtask

  task automatic test_full_store();
    set_threshold(100);
    no_gaps = 1'b1;
    send_word(OP_CLEAR, '0, 16'h0);
    repeat (MAX_TRAIN + 3) send_word(OP_APPEND, random_desc(), 16'($urandom));
    repeat (40) begin
      if ($urandom_range(3) == 0) send_word(OP_QUERY, random_desc(), 16'($urandom));
      else send_near_query();
    end
    no_gaps = 1'b0;
  endtask

  task automatic run_session(int threshold, int n_train, int n_ops);
    int pick;
    set_threshold(threshold);
    send_word(OP_CLEAR, random_desc(), 16'($urandom));
    repeat (n_train) send_word(OP_APPEND, random_desc(), 16'($urandom));
    repeat (n_ops) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_near_query();
      end else if (pick < 80) begin
        send_word(OP_QUERY, random_desc(), 16'($urandom));
      end else if (pick < 90) begin
        send_word(OP_APPEND, random_desc(), 16'($urandom));
      end else if (pick < 93) begin
        send_word(OP_UNUSED, random_desc(), 16'($urandom));
      end else if (pick < 95) begin
        send_word(OP_CLEAR, random_desc(), 16'($urandom));
      end else begin
        wait_results();
        send_near_query();
      end
    end
  endtask

  task automatic test_thresholds();
    int levels[10];
    levels = '{0, 257, 1, 256, 64, 128, 255, 0, 0, 0};
    for (int i = 7; i < 10; i++) levels[i] = $urandom_range(257);
    foreach (levels[i]) begin
      run_session(levels[i], $urandom_range(1, 40), $urandom_range(50, 70));
    end
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    release_input();
    while (pending_matches.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (pending_matches.size() != 0) begin
      report_error($sformatf("no result for tag %h", pending_matches[0].tag));
      void'(pending_matches.pop_front());
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_chan.valid      = 1'b0;
    in_chan.operation  = OP_CLEAR;
    in_chan.desc_word0 = '0;
    in_chan.desc_word1 = '0;
    in_chan.desc_word2 = '0;
    in_chan.desc_word3 = '0;
    in_chan.query_tag  = '0;
    no_gaps            = 1'b0;
    train_count        = 0;
    max_dist           = MAXD_RESET;
    foreach (train_used[i]) train_used[i] = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_full_store();
    test_thresholds();
    drain_results();

    $display("sent %0d words with %0d queries under %0d threshold settings",
             words_sent, queries_sent, thresholds_set);
    $display("checked %0d results, %0d of them matches, %0d errors",
             results_seen, matches_seen, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
hdl/ghdm_pkg.sv
hdl/ghdm_in_if.sv
hdl/ghdm_out_if.sv
hdl/ghdm_front.sv
hdl/ghdm_cmd_queue.sv
hdl/ghdm_bank.sv
hdl/ghdm_back.sv
hdl/greedy_hamming_descriptor_matcher.sv
hdl/ghdm_checker.sv
test/testbench.sv
